// ===== hdl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the pair distance histogram RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge of aclk while out of reset.
`define PDH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// An implication checked in the same cycle while out of reset.
`define PDH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pdh_pkg.sv =====
// ============================================================================
// pdh_pkg
// Types, widths, codes and reset values shared by the pair distance
// histogram modules.
// ============================================================================
package pdh_pkg;

    // Field widths.
    localparam int COORD_W = 20;
    localparam int CLASS_W = 2;
    localparam int INDEX_W = 8;
    localparam int BINS_W  = 9;
    localparam int COUNT_W = 32;

    // Datapath widths: signed axis difference, squared distance, root.
    localparam int DIFF_W = 21;
    localparam int SQ_W   = 42;
    localparam int ROOT_W = 21;

    localparam int NUM_CLASSES      = 3;
    localparam int NUM_BINS_DEFAULT = 256;
    localparam int QUEUE_DEPTH      = 2;

    // Register port.
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_BOX_LENGTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BINS_IN_USE = 2'd2;

    localparam logic [COORD_W-1:0] BOX_LENGTH_RESET  = 20'hFFFFF;
    localparam logic [COORD_W-1:0] BIN_WIDTH_RESET   = 20'd2048;
    localparam logic [BINS_W-1:0]  BINS_IN_USE_RESET = 9'd256;

    localparam logic [COORD_W-1:0] BIN_INDEX_MAX = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 32'hFFFFFFFF;

    // Item function codes.
    localparam logic FUNC_ACCUMULATE = 1'b0;
    localparam logic FUNC_READ       = 1'b1;

    // Pair classes.
    localparam logic [CLASS_W-1:0] CLASS_AA = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_BB = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_AB = 2'd2;

    typedef struct packed {
        logic               func;
        logic [CLASS_W-1:0] pair_class;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] first_z;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [COORD_W-1:0] second_z;
        logic [INDEX_W-1:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] bin_index;
        logic               counted;
        logic [COUNT_W-1:0] bin_count;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] box_length;
        logic [COORD_W-1:0] bin_width;
        logic [BINS_W-1:0]  bins_in_use;
    } cfg_t;

    // What the histogram side has to do for one item.
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ACC  = 2'd1,
        CMD_READ = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CLASS_W-1:0] pair_class;
        logic [COORD_W-1:0] bin_index;
    } cmd_t;

endpackage

// ===== hdl/pdh_front.sv =====
// ============================================================================
// pdh_front
// Accepts items, computes for accumulate items the minimum-image distance,
// its integer square root and the bin, and classifies each item into a histogram command.
// ============================================================================
`include "assert_macros.svh"

module pdh_front #(
    parameter int NUM_BINS = pdh_pkg::NUM_BINS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             hold,
    input  pdh_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  pdh_pkg::in_item_t s_item,
    output logic             push_valid,
    input  logic             push_ready,
    output pdh_pkg::cmd_t    push_cmd
);

    localparam int DIFF_W  = pdh_pkg::DIFF_W;
    localparam int SQ_W    = pdh_pkg::SQ_W;
    localparam int QUO_W   = pdh_pkg::ROOT_W;
    localparam int COORD_W = pdh_pkg::COORD_W;
    localparam int STEP_W  = $clog2(QUO_W);

    localparam logic [STEP_W-1:0] SQR_LAST      = STEP_W'(3);
    localparam logic [STEP_W-1:0] DIV_LAST      = STEP_W'(QUO_W - 1);
    localparam logic [SQ_W-1:0]   ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);
    localparam logic [QUO_W-1:0]  NUM_BINS_Q    = QUO_W'(NUM_BINS);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_WRAP = 6'b000010,
        F_SQR  = 6'b000100,
        F_ROOT = 6'b001000,
        F_DIV  = 6'b010000,
        F_PUSH = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    pdh_pkg::in_item_t        item_reg;
    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [DIFF_W-1:0] wrap_reg [3];
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          d2_reg;
    logic [SQ_W-1:0]          res_reg;
    logic [SQ_W-1:0]          bit_reg;
    logic [QUO_W-1:0]         num_reg;
    logic [COORD_W-1:0]       rem_reg;
    logic [STEP_W-1:0]        step_reg;

    logic signed [DIFF_W-1:0] in_diff  [3];
    logic signed [DIFF_W-1:0] wrap_val [3];
    logic signed [SQ_W-1:0]   prod;
    logic [SQ_W-1:0]          trial;
    logic                     root_ge;
    logic [SQ_W-1:0]          res_next;
    logic [COORD_W-1:0]       div_w;
    logic [QUO_W-1:0]         div_trial;
    logic [QUO_W-1:0]         div_sub;
    logic                     div_ge;
    logic [COORD_W-1:0]       rem_next;
    logic                     cls_ok;

    assign s_ready    = (state_reg == F_IDLE) && !hold;
    assign push_valid = (state_reg == F_PUSH);

    // Per-axis differences of the incoming item.
    always_comb begin
        in_diff[0] = $signed({1'b0, s_item.second_x}) - $signed({1'b0, s_item.first_x});
        in_diff[1] = $signed({1'b0, s_item.second_y}) - $signed({1'b0, s_item.first_y});
        in_diff[2] = $signed({1'b0, s_item.second_z}) - $signed({1'b0, s_item.first_z});
    end

    // Minimum-image correction: at most one shift by the box edge per axis.
    always_comb begin
        logic signed [DIFF_W:0] len_s;
        logic signed [DIFF_W:0] twice;
        logic signed [DIFF_W:0] wide_d;
        logic signed [DIFF_W:0] shifted;
        len_s = $signed({2'b00, cfg.box_length});
        for (int k = 0; k < 3; k++) begin
            wide_d = {diff_reg[k][DIFF_W-1], diff_reg[k]};
            twice  = {diff_reg[k], 1'b0};
            if (twice > len_s) begin
                shifted = wide_d - len_s;
            end else if (twice < -len_s) begin
                shifted = wide_d + len_s;
            end else begin
                shifted = wide_d;
            end
            wrap_val[k] = shifted[DIFF_W-1:0];
        end
    end

    // One shared squarer, fed from the head of the axis shift line.
    assign prod = wrap_reg[0] * wrap_reg[0];

    // One step of the digit-by-digit square root.
    always_comb begin
        trial    = res_reg + bit_reg;
        root_ge  = (d2_reg >= trial);
        res_next = root_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // One step of the restoring division by the bin width.
    always_comb begin
        div_w     = (cfg.bin_width == '0) ? COORD_W'(1) : cfg.bin_width;
        div_trial = {rem_reg, num_reg[QUO_W-1]};
        div_sub   = div_trial - {1'b0, div_w};
        div_ge    = (div_trial >= {1'b0, div_w});
        rem_next  = div_ge ? div_sub[COORD_W-1:0] : div_trial[COORD_W-1:0];
    end

    // Classify the finished item into a histogram command.
    always_comb begin
        cls_ok = (item_reg.pair_class < pdh_pkg::CLASS_W'(pdh_pkg::NUM_CLASSES));
        push_cmd.pair_class = item_reg.pair_class;
        if (item_reg.func == pdh_pkg::FUNC_READ) begin
            push_cmd.bin_index = COORD_W'(item_reg.read_index);
            push_cmd.kind = (cls_ok && (QUO_W'(item_reg.read_index) < NUM_BINS_Q)) ?
                            pdh_pkg::CMD_READ : pdh_pkg::CMD_NONE;
        end else begin
            push_cmd.bin_index = (num_reg > QUO_W'(pdh_pkg::BIN_INDEX_MAX)) ?
                                 pdh_pkg::BIN_INDEX_MAX : num_reg[COORD_W-1:0];
            push_cmd.kind = (cls_ok && (num_reg < QUO_W'(cfg.bins_in_use)) &&
                             (num_reg < NUM_BINS_Q)) ? pdh_pkg::CMD_ACC : pdh_pkg::CMD_NONE;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (s_valid && s_ready) begin
                state_next = (s_item.func == pdh_pkg::FUNC_READ) ? F_PUSH : F_WRAP;
            end
            F_WRAP: state_next = F_SQR;
            F_SQR: if (step_reg == SQR_LAST) begin
                state_next = F_ROOT;
            end
            F_ROOT: if (bit_reg[0]) begin
                state_next = F_DIV;
            end
            F_DIV: if (step_reg == DIV_LAST) begin
                state_next = F_PUSH;
            end
            F_PUSH: if (push_ready) begin
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: if (s_valid && s_ready) begin
                item_reg <= s_item;
                diff_reg <= in_diff;
            end
            F_WRAP: begin
                wrap_reg <= wrap_val;
                step_reg <= '0;
            end
            F_SQR: begin
                sq_reg      <= $unsigned(prod);
                wrap_reg[0] <= wrap_reg[1];
                wrap_reg[1] <= wrap_reg[2];
                d2_reg      <= (step_reg == '0) ? '0 : (d2_reg + sq_reg);
                step_reg    <= step_reg + STEP_W'(1);
                res_reg     <= '0;
                bit_reg     <= ROOT_BIT_INIT;
            end
            F_ROOT: begin
                if (root_ge) begin
                    d2_reg <= d2_reg - trial;
                end
                res_reg  <= res_next;
                bit_reg  <= bit_reg >> 2;
                num_reg  <= res_next[QUO_W-1:0];
                rem_reg  <= '0;
                step_reg <= '0;
            end
            F_DIV: begin
                num_reg  <= {num_reg[QUO_W-2:0], div_ge};
                rem_reg  <= rem_next;
                step_reg <= step_reg + STEP_W'(1);
            end
            default: ;
        endcase
    end

    // An accepted accumulate item always starts with the wrap step.
    `PDH_ASSERT(a_acc_starts_wrap,
        (s_valid && s_ready && s_item.func == pdh_pkg::FUNC_ACCUMULATE) |=> (state_reg == F_WRAP),
        "accumulate item did not enter the wrap step")

    // A counted bin must lie inside the histogram.
    `PDH_ASSERT_IMP(a_acc_bin_in_range,
        push_valid && push_cmd.kind == pdh_pkg::CMD_ACC,
        push_cmd.bin_index < COORD_W'(NUM_BINS),
        "accumulate command addresses a bin beyond the histogram")

endmodule

// ===== hdl/pdh_queue.sv =====
// ============================================================================
// pdh_queue
// Short command queue between the distance front end and the histogram
// back end.
// ============================================================================
`include "assert_macros.svh"

module pdh_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  pdh_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pdh_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = pdh_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pdh_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : (wr_ptr_reg + PTR_W'(1));
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : (rd_ptr_reg + PTR_W'(1));
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Command storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // A command pushed into an empty queue is offered in the next cycle.
    `PDH_ASSERT(a_push_visible,
        (do_push && count_reg == '0) |=> pop_valid,
        "pushed command not visible at the queue head")

endmodule

// ===== hdl/pdh_back.sv =====
// ============================================================================
// pdh_back
// Histogram memory for all pair classes: read-modify-write of one bin per
// command, read-and-clear, and the clearing sweep after reset.
// ============================================================================
`include "assert_macros.svh"

module pdh_back #(
    parameter int NUM_BINS = pdh_pkg::NUM_BINS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    output logic               clearing,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  pdh_pkg::cmd_t      pop_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output pdh_pkg::out_item_t m_item
);

    localparam int COUNT_W    = pdh_pkg::COUNT_W;
    localparam int HIST_DEPTH = pdh_pkg::NUM_CLASSES * NUM_BINS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int BIN_AW     = $clog2(NUM_BINS);

    localparam logic [HIST_AW-1:0] ROW_STRIDE   = HIST_AW'(NUM_BINS);
    localparam logic [HIST_AW-1:0] ROW_STRIDE_2 = HIST_AW'(2 * NUM_BINS);
    localparam logic [HIST_AW-1:0] CLEAR_LAST   = HIST_AW'(HIST_DEPTH - 1);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_WRITE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [COUNT_W-1:0] hist_mem [HIST_DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;
    logic [HIST_AW-1:0] clr_cnt_reg;
    logic [HIST_AW-1:0] addr_reg;
    pdh_pkg::cmd_t      cmd_reg;
    pdh_pkg::out_item_t m_item_reg;
    logic               m_valid_reg;

    logic [HIST_AW-1:0] row_base;
    logic [HIST_AW-1:0] pop_addr;
    logic               out_free;
    logic               finish;
    logic               mem_rd_en;
    logic               mem_wr_en;
    logic [HIST_AW-1:0] mem_wr_addr;
    logic [COUNT_W-1:0] mem_wr_data;
    logic [COUNT_W-1:0] inc_count;
    logic [COUNT_W-1:0] new_count;
    logic [COUNT_W-1:0] out_count;
    logic               out_counted;

    assign clearing  = (state_reg == B_CLEAR);
    assign pop_ready = (state_reg == B_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == B_WRITE) && out_free;
    assign mem_rd_en = pop_valid && pop_ready && (pop_cmd.kind != pdh_pkg::CMD_NONE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // Memory address of the command at the queue head.
    always_comb begin
        case (pop_cmd.pair_class)
            pdh_pkg::CLASS_BB: row_base = ROW_STRIDE;
            pdh_pkg::CLASS_AB: row_base = ROW_STRIDE_2;
            default:           row_base = '0;
        endcase
        pop_addr = row_base + HIST_AW'(pop_cmd.bin_index[BIN_AW-1:0]);
    end

    // New bin value and result fields; the increment saturates.
    always_comb begin
        inc_count = (rd_data_reg == pdh_pkg::COUNT_MAX) ? rd_data_reg :
                    (rd_data_reg + COUNT_W'(1));
        case (cmd_reg.kind)
            pdh_pkg::CMD_ACC: begin
                new_count   = inc_count;
                out_count   = inc_count;
                out_counted = 1'b1;
            end
            pdh_pkg::CMD_READ: begin
                new_count   = '0;
                out_count   = rd_data_reg;
                out_counted = 1'b0;
            end
            default: begin
                new_count   = '0;
                out_count   = '0;
                out_counted = 1'b0;
            end
        endcase
    end

    // Write port: clearing sweep or write-back of the updated bin.
    always_comb begin
        mem_wr_en   = clearing || (finish && (cmd_reg.kind != pdh_pkg::CMD_NONE));
        mem_wr_addr = clearing ? clr_cnt_reg : addr_reg;
        mem_wr_data = clearing ? '0 : new_count;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            hist_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= hist_mem[pop_addr];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: if (clr_cnt_reg == CLEAR_LAST) begin
                state_next = B_IDLE;
            end
            B_IDLE: if (pop_valid) begin
                state_next = B_WRITE;
            end
            B_WRITE: if (out_free) begin
                state_next = B_IDLE;
            end
            default: state_next = B_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + HIST_AW'(1);
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command and result payload.
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            cmd_reg  <= pop_cmd;
            addr_reg <= pop_addr;
        end
        if (finish) begin
            m_item_reg.bin_index <= cmd_reg.bin_index;
            m_item_reg.counted   <= out_counted;
            m_item_reg.bin_count <= out_count;
        end
    end

    // A taken command always moves to the write step in the next cycle.
    `PDH_ASSERT(a_pop_then_write,
        (pop_valid && pop_ready) |=> (state_reg == B_WRITE),
        "popped command did not reach the write step")

    // A counted result has at least one hit in its bin.
    `PDH_ASSERT_IMP(a_counted_nonzero,
        m_valid && m_item.counted,
        m_item.bin_count != '0,
        "counted result reports an empty bin")

endmodule

// ===== hdl/pair_distance_histogram.sv =====
// ============================================================================
// pair_distance_histogram
// Radial distribution histogram of point pairs in a periodic cubic box,
// one histogram per pair class, with read-and-clear of single bins.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_item carry one item: an accumulate of a point pair or
//   a read-and-clear of one bin. m_valid/m_ready/m_item return exactly one
//   result item per input item, in order.
//   The APB port sets box_length, bin_width and bins_in_use; write them only
//   while no item is in flight.
//   An accumulate item occupies the front end for the wrap, three squares
//   and a sum, 21 square-root steps and 21 divide steps. A read item skips
//   these steps. The histogram side takes a new command only after it has
//   written back the last one, and holds it while the output is stalled.
//   After reset the histogram memory is swept to zero, one bin a cycle, over
//   all 3*NUM_BINS bins; s_ready stays low during the sweep, while register
//   writes are taken as usual.
//   When the receiver stalls, the result waits in the output register, the
//   two-entry command queue fills, and then s_ready drops.
// ============================================================================
module pair_distance_histogram #(
    parameter int NUM_BINS = pdh_pkg::NUM_BINS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pdh_pkg::in_item_t             s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pdh_pkg::out_item_t            m_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdh_pkg::PADDR_W-1:0]   paddr,
    input  logic [pdh_pkg::PDATA_W-1:0]   pwdata,
    output logic [pdh_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int COORD_W = pdh_pkg::COORD_W;
    localparam int BINS_W  = pdh_pkg::BINS_W;
    localparam int PDATA_W = pdh_pkg::PDATA_W;
    localparam int IDX_W   = pdh_pkg::REG_IDX_W;

    logic [COORD_W-1:0] box_length_reg;
    logic [COORD_W-1:0] bin_width_reg;
    logic [BINS_W-1:0]  bins_in_use_reg;
    logic [IDX_W-1:0]   reg_idx;
    logic               cfg_write;
    pdh_pkg::cfg_t      cfg;

    logic          hold;
    logic          push_valid, push_ready;
    logic          pop_valid, pop_ready;
    pdh_pkg::cmd_t push_cmd, pop_cmd;

    // Register port.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[IDX_W+1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_length_reg  <= pdh_pkg::BOX_LENGTH_RESET;
            bin_width_reg   <= pdh_pkg::BIN_WIDTH_RESET;
            bins_in_use_reg <= pdh_pkg::BINS_IN_USE_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                pdh_pkg::REG_BOX_LENGTH:  box_length_reg  <= pwdata[COORD_W-1:0];
                pdh_pkg::REG_BIN_WIDTH:   bin_width_reg   <= pwdata[COORD_W-1:0];
                pdh_pkg::REG_BINS_IN_USE: bins_in_use_reg <= pwdata[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pdh_pkg::REG_BOX_LENGTH:  prdata = PDATA_W'(box_length_reg);
            pdh_pkg::REG_BIN_WIDTH:   prdata = PDATA_W'(bin_width_reg);
            pdh_pkg::REG_BINS_IN_USE: prdata = PDATA_W'(bins_in_use_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.box_length  = box_length_reg;
    assign cfg.bin_width   = bin_width_reg;
    assign cfg.bins_in_use = bins_in_use_reg;

    pdh_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hold       (hold),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    pdh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    pdh_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clearing  (hold),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== tb/tb_pair_distance_histogram.sv =====
// ============================================================================
// tb_pair_distance_histogram
// Self-checking testbench for the pair distance histogram. A directed table
// covers reset state, minimum-image wrap, bin edges, the unused class and
// register extremes. Random phases under several register settings follow.
// A behavioral histogram inside the testbench predicts every result, and
// both handshakes stall at random.
// ============================================================================
module tb_pair_distance_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    // Package widths, types and codes used here.
    localparam int NUM_BINS_DEFAULT = pdh_pkg::NUM_BINS_DEFAULT;
    localparam int NUM_CLASSES      = pdh_pkg::NUM_CLASSES;
    localparam int CLASS_W          = pdh_pkg::CLASS_W;
    localparam int COORD_W          = pdh_pkg::COORD_W;
    localparam int INDEX_W          = pdh_pkg::INDEX_W;
    localparam int BINS_W           = pdh_pkg::BINS_W;
    localparam int COUNT_W          = pdh_pkg::COUNT_W;
    localparam int REG_IDX_W        = pdh_pkg::REG_IDX_W;
    localparam int PADDR_W          = pdh_pkg::PADDR_W;
    localparam int PDATA_W          = pdh_pkg::PDATA_W;

    typedef pdh_pkg::in_item_t  in_item_t;
    typedef pdh_pkg::out_item_t out_item_t;

    localparam logic FUNC_ACCUMULATE = pdh_pkg::FUNC_ACCUMULATE;
    localparam logic FUNC_READ       = pdh_pkg::FUNC_READ;

    localparam logic [CLASS_W-1:0] CLASS_AA = pdh_pkg::CLASS_AA;
    localparam logic [CLASS_W-1:0] CLASS_BB = pdh_pkg::CLASS_BB;
    localparam logic [CLASS_W-1:0] CLASS_AB = pdh_pkg::CLASS_AB;

    localparam logic [REG_IDX_W-1:0] REG_BOX_LENGTH  = pdh_pkg::REG_BOX_LENGTH;
    localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH   = pdh_pkg::REG_BIN_WIDTH;
    localparam logic [REG_IDX_W-1:0] REG_BINS_IN_USE = pdh_pkg::REG_BINS_IN_USE;

    localparam logic [COORD_W-1:0] BOX_LENGTH_RESET  = pdh_pkg::BOX_LENGTH_RESET;
    localparam logic [COORD_W-1:0] BIN_WIDTH_RESET   = pdh_pkg::BIN_WIDTH_RESET;
    localparam logic [BINS_W-1:0]  BINS_IN_USE_RESET = pdh_pkg::BINS_IN_USE_RESET;
    localparam logic [COORD_W-1:0] BIN_INDEX_MAX     = pdh_pkg::BIN_INDEX_MAX;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = pdh_pkg::COUNT_MAX;

    localparam int N_BINS      = NUM_BINS_DEFAULT;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 8;
    localparam int TAIL_CYCLES = 60;

    localparam logic [CLASS_W-1:0] CLASS_UNUSED = 2'd3;
    localparam logic [COORD_W-1:0] CMAX         = 20'hFFFFF;

    // One line of the directed table: a register write or an item.
    typedef struct {
        bit                   is_reg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [PDATA_W-1:0]   reg_val;
        in_item_t             item;
        bit                   typed;
        out_item_t            want;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_item;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Testbench copy of the registers and of the class histograms.
    logic [COORD_W-1:0] box_len;
    logic [COORD_W-1:0] bin_w;
    logic [BINS_W-1:0]  bins_used;
    logic [COUNT_W-1:0] hist_shadow [NUM_CLASSES][N_BINS];

    out_item_t bin_reports_due[$];
    plan_row_t directed_plan[$];
    int        mismatches;
    int        idle_cycles;
    bit        quiet;
    bit        hold_request;
    int        stall_left;

    pair_distance_histogram dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Signed per-axis separation after the single minimum-image shift.
    function automatic longint axis_gap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        longint d;
        longint edge_len;
        d = b;
        d = d - longint'(a);
        edge_len = box_len;
        if (2 * d > edge_len) d = d - edge_len;
        if (2 * d < -edge_len) d = d + edge_len;
        return d;
    endfunction

    // Floor square root by building the root one bit at a time.
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 22; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v) root = cand;
        end
        return root;
    endfunction

    // Predicts the result of one item and updates the histogram copy.
    function automatic out_item_t histogram_step(in_item_t it);
        out_item_t      r;
        longint         dx;
        longint         dy;
        longint         dz;
        longint unsigned d2;
        longint unsigned bin;
        longint unsigned wid;
        longint unsigned lim;
        r = '0;
        if (it.func == FUNC_READ) begin
            r.bin_index = COORD_W'(it.read_index);
            if (it.pair_class != CLASS_UNUSED && int'(it.read_index) < N_BINS) begin
                r.bin_count = hist_shadow[it.pair_class][it.read_index];
                hist_shadow[it.pair_class][it.read_index] = '0;
            end
            return r;
        end
        dx  = axis_gap(it.first_x, it.second_x);
        dy  = axis_gap(it.first_y, it.second_y);
        dz  = axis_gap(it.first_z, it.second_z);
        d2  = dx * dx + dy * dy + dz * dz;
        wid = (bin_w == '0) ? 1 : bin_w;
        bin = floor_root(d2) / wid;
        lim = (bins_used > N_BINS) ? N_BINS : bins_used;
        r.bin_index = (bin > CMAX) ? BIN_INDEX_MAX : bin[COORD_W-1:0];
        if (it.pair_class != CLASS_UNUSED && bin < lim) begin
            if (hist_shadow[it.pair_class][bin] != COUNT_MAX)
                hist_shadow[it.pair_class][bin] = hist_shadow[it.pair_class][bin] + 1;
            r.counted   = 1'b1;
            r.bin_count = hist_shadow[it.pair_class][bin];
        end
        return r;
    endfunction

    function automatic out_item_t want(int unsigned b, bit c, logic [COUNT_W-1:0] n);
        out_item_t r;
        r.bin_index = b[COORD_W-1:0];
        r.counted   = c;
        r.bin_count = n;
        return r;
    endfunction

    function automatic plan_row_t acc_row(logic [CLASS_W-1:0] cls,
                                          logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                                          logic [COORD_W-1:0] fz, logic [COORD_W-1:0] sx,
                                          logic [COORD_W-1:0] sy, logic [COORD_W-1:0] sz,
                                          bit typed, out_item_t w);
        plan_row_t row;
        row.is_reg          = 1'b0;
        row.reg_idx         = '0;
        row.reg_val         = '0;
        row.item            = '0;
        row.item.func       = FUNC_ACCUMULATE;
        row.item.pair_class = cls;
        row.item.first_x    = fx;
        row.item.first_y    = fy;
        row.item.first_z    = fz;
        row.item.second_x   = sx;
        row.item.second_y   = sy;
        row.item.second_z   = sz;
        row.typed           = typed;
        row.want            = w;
        return row;
    endfunction

    function automatic plan_row_t rd_row(logic [CLASS_W-1:0] cls, logic [INDEX_W-1:0] idx,
                                         out_item_t w);
        plan_row_t row;
        row = acc_row(cls, '0, '0, '0, '0, '0, '0, 1'b1, w);
        row.item.func       = FUNC_READ;
        row.item.read_index = idx;
        return row;
    endfunction

    function automatic plan_row_t reg_row(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] v);
        plan_row_t row;
        row         = acc_row('0, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = v;
        return row;
    endfunction

    // Random item: mostly pairs close enough to land in a counted bin.
    function automatic in_item_t random_pair_item();
        in_item_t           it;
        int unsigned        wid;
        int unsigned        lim;
        int unsigned        span;
        int unsigned        delta;
        int unsigned        mode;
        logic [COORD_W-1:0] f [3];
        logic [COORD_W-1:0] s [3];
        wid  = (bin_w == '0) ? 1 : bin_w;
        lim  = (bins_used > N_BINS) ? N_BINS : bins_used;
        if (lim == 0) lim = 1;
        span = wid * lim / 2;
        if (span > CMAX) span = CMAX;
        mode = $urandom_range(0, 3);
        for (int a = 0; a < 3; a++) begin
            if (mode == 0) begin
                f[a] = COORD_W'($urandom);
                s[a] = COORD_W'($urandom);
            end else begin
                f[a]  = COORD_W'($urandom_range(0, (box_len == '0) ? 0 : box_len - 1));
                delta = $urandom_range(0, span);
                s[a]  = $urandom_range(0, 1) ? f[a] + COORD_W'(delta) : f[a] - COORD_W'(delta);
            end
        end
        it.func       = ($urandom_range(0, 4) == 0) ? FUNC_READ : FUNC_ACCUMULATE;
        it.pair_class = ($urandom_range(0, 9) == 0) ? CLASS_UNUSED
                                                    : CLASS_W'($urandom_range(0, 2));
        it.first_x    = f[0];
        it.first_y    = f[1];
        it.first_z    = f[2];
        it.second_x   = s[0];
        it.second_y   = s[1];
        it.second_z   = s[2];
        it.read_index = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom)
                                                    : INDEX_W'($urandom_range(0, lim - 1));
        return it;
    endfunction

    // Offers one item, with an occasional gap first, and records its result.
    task automatic send_item(in_item_t it, bit typed, out_item_t w);
        out_item_t r;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        r = histogram_step(it);
        bin_reports_due.push_back(typed ? w : r);
    endtask

    // Stops offering items and waits for every outstanding result.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (bin_reports_due.size() != 0) @(posedge aclk);
    endtask

    // Writes one register, then reads it back.
    task automatic reg_set(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] held;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_BOX_LENGTH: begin
                box_len = value[COORD_W-1:0];
                held    = PDATA_W'(box_len);
            end
            REG_BIN_WIDTH: begin
                bin_w = value[COORD_W-1:0];
                held  = PDATA_W'(bin_w);
            end
            default: begin
                bins_used = value[BINS_W-1:0];
                held      = PDATA_W'(bins_used);
            end
        endcase
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== held) begin
            $display("%0t: register %0d expected %0h actual %0h", $time, idx, held, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: random stall bursts, one long hold on request, none when quiet.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_request) begin
            m_ready      <= 1'b0;
            stall_left   <= LONG_HOLD - 1;
            hold_request <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t due;
        if (aresetn && m_valid && m_ready) begin
            if (bin_reports_due.size() == 0) begin
                $display("%0t: result with none expected: actual %p", $time, m_item);
                mismatches++;
            end else begin
                due = bin_reports_due.pop_front();
                if (m_item.bin_index !== due.bin_index) begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, due.bin_index, m_item.bin_index);
                    mismatches++;
                end
                if (m_item.counted !== due.counted) begin
                    $display("%0t: counted expected %0d actual %0d",
                             $time, due.counted, m_item.counted);
                    mismatches++;
                end
                if (m_item.bin_count !== due.bin_count) begin
                    $display("%0t: bin_count expected %0d actual %0d",
                             $time, due.bin_count, m_item.bin_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which nothing at all is accepted.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_pair_distance_histogram NOT OK");
            $finish;
        end
    end

    initial begin
        logic [COORD_W-1:0] phase_box [NUM_PHASES];
        logic [COORD_W-1:0] phase_wid [NUM_PHASES];
        logic [BINS_W-1:0]  phase_bins [NUM_PHASES];
        plan_row_t          row;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        m_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        stall_left   = 0;
        box_len      = BOX_LENGTH_RESET;
        bin_w        = BIN_WIDTH_RESET;
        bins_used    = BINS_IN_USE_RESET;
        foreach (hist_shadow[c, b]) hist_shadow[c][b] = '0;

        // Directed table. Reset registers: box full range, width 2048, 256 bins.
        directed_plan.push_back(rd_row(CLASS_AA, 8'd0, want(0, 0, 0)));
        directed_plan.push_back(rd_row(CLASS_AB, 8'd255, want(255, 0, 0)));
        directed_plan.push_back(acc_row(CLASS_AA, 0, 0, 0, 0, 0, 0, 1, want(0, 1, 1)));
        // Opposite corners wrap to zero separation in both directions.
        directed_plan.push_back(acc_row(CLASS_AA, 0, 0, 0, CMAX, CMAX, CMAX, 1, want(0, 1, 2)));
        directed_plan.push_back(acc_row(CLASS_AB, CMAX, CMAX, CMAX, 0, 0, 0, 1, want(0, 1, 1)));
        // The unused class leaves every histogram alone.
        directed_plan.push_back(acc_row(CLASS_UNUSED, 0, 0, 0, 0, 0, 0, 1, want(0, 0, 0)));
        directed_plan.push_back(rd_row(CLASS_UNUSED, 8'd0, want(0, 0, 0)));
        directed_plan.push_back(acc_row(CLASS_BB, 0, 0, 0, 2048, 0, 0, 1, want(1, 1, 1)));
        // Just below and just above half the box on one axis.
        directed_plan.push_back(acc_row(CLASS_AB, 0, 0, 0, 524287, 0, 0, 1, want(255, 1, 1)));
        directed_plan.push_back(acc_row(CLASS_AB, 0, 0, 0, 524288, 0, 0, 1, want(255, 1, 2)));
        // Beyond the last bin in use.
        directed_plan.push_back(acc_row(CLASS_AA, 0, 0, 0, 400000, 400000, 400000, 1,
                                        want(338, 0, 0)));
        directed_plan.push_back(acc_row(CLASS_BB, 12345, 678901, 1000, 13000, 677000, 3000,
                                        0, '0));
        directed_plan.push_back(rd_row(CLASS_AA, 8'd0, want(0, 0, 2)));
        directed_plan.push_back(rd_row(CLASS_AB, 8'd255, want(255, 0, 2)));
        directed_plan.push_back(rd_row(CLASS_BB, 8'd1, want(1, 0, 2)));
        directed_plan.push_back(rd_row(CLASS_AB, 8'd0, want(0, 0, 1)));
        directed_plan.push_back(rd_row(CLASS_AB, 8'd0, want(0, 0, 0)));
        // Tiny box, zero width and no bins: the bin saturates and nothing counts.
        directed_plan.push_back(reg_row(REG_BOX_LENGTH, 1));
        directed_plan.push_back(reg_row(REG_BIN_WIDTH, 0));
        directed_plan.push_back(reg_row(REG_BINS_IN_USE, 0));
        directed_plan.push_back(acc_row(CLASS_AA, 0, 0, 0, CMAX, CMAX, CMAX, 1,
                                        want(CMAX, 0, 0)));
        directed_plan.push_back(acc_row(CLASS_AA, 0, 0, 0, 0, 0, 0, 1, want(0, 0, 0)));
        // Widest bin and more bins than the memory holds.
        directed_plan.push_back(reg_row(REG_BOX_LENGTH, CMAX));
        directed_plan.push_back(reg_row(REG_BIN_WIDTH, CMAX));
        directed_plan.push_back(reg_row(REG_BINS_IN_USE, 511));
        directed_plan.push_back(acc_row(CLASS_BB, 0, 0, 0, 0, 0, 1000, 1, want(0, 1, 1)));
        directed_plan.push_back(acc_row(CLASS_AA, 0, 0, 0, 524287, 524287, 524287, 1,
                                        want(0, 1, 1)));
        // Unit width: the last bin counts, the next one does not.
        directed_plan.push_back(reg_row(REG_BIN_WIDTH, 1));
        directed_plan.push_back(reg_row(REG_BINS_IN_USE, 256));
        directed_plan.push_back(acc_row(CLASS_AB, 0, 0, 0, 255, 0, 0, 1, want(255, 1, 1)));
        directed_plan.push_back(acc_row(CLASS_AB, 0, 0, 0, 256, 0, 0, 1, want(256, 0, 0)));
        row = rd_row(CLASS_BB, 8'hFF, want(255, 0, 0));
        row.item.first_x  = CMAX;
        row.item.first_y  = CMAX;
        row.item.first_z  = CMAX;
        row.item.second_x = CMAX;
        row.item.second_y = CMAX;
        row.item.second_z = CMAX;
        directed_plan.push_back(row);
        directed_plan.push_back(acc_row(CLASS_AA, 100, 200, 300, 150, 260, 310, 0, '0));

        // Random phases: extremes of every register, then random settings.
        phase_box  = '{CMAX, 1, CMAX, 1000, 0, 300000, 0, CMAX};
        phase_wid  = '{2048, 1, CMAX, 0, 0, 1200, 0, 64};
        phase_bins = '{256, 256, 1, 511, 0, 200, 0, 256};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_reg) begin
                wait_for_results();
                reg_set(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end else begin
                send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_results();
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            // A zero in the phase settings picks a random value, but the bin width of phase 3 stays zero.
            reg_set(REG_BOX_LENGTH, (phase_box[p] != '0) ? phase_box[p]
                                                         : $urandom_range(1, CMAX));
            reg_set(REG_BIN_WIDTH, (phase_wid[p] != '0 || p == 3) ? phase_wid[p]
                                                                  : $urandom_range(1, 4096));
            reg_set(REG_BINS_IN_USE, (phase_bins[p] != '0) ? phase_bins[p]
                                                           : $urandom_range(1, 256));
            // Hold the receiver off long enough for the block to stop taking items.
            if (p == 5) hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_item(random_pair_item(), 1'b0, '0);
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_pair_distance_histogram OK");
        end else begin
            $display("tb_pair_distance_histogram NOT OK");
        end
        $finish;
    end

endmodule
